/* rtl/lgs_pkg.sv */
// Shared types and constants of the Laplace Gauss-Seidel solver.
package lgs_pkg;
  localparam int GridMax    = 64;
  localparam int IdxW       = $clog2(GridMax);
  localparam int AddrW      = 2 * IdxW;
  localparam int ValW       = 32;
  localparam int SizeW      = 7;
  localparam int TolW       = 31;
  localparam int SweepW     = 16;

  localparam logic [1:0] KindWrite = 2'd0;
  localparam logic [1:0] KindSolve = 2'd1;
  localparam logic [1:0] KindRead  = 2'd2;

  localparam logic [3:0] RegGridSize  = 4'h0;
  localparam logic [3:0] RegTolerance = 4'h4;
  localparam logic [3:0] RegMaxSweeps = 4'h8;

  typedef struct packed {
    logic             re;
    logic             we;
    logic [AddrW-1:0] addr;
    logic [ValW-1:0]  wdata;
  } mem_req_t;

  typedef struct packed {
    logic              busy;
    logic [SweepW-1:0] sweeps;
    logic              converged;
  } relax_stat_t;
endpackage

/* rtl/laplace_gauss_seidel_solver_core.sv */
// Top level: stream request port, APB registers, grid store and sweep sequencer.
// Writes and reads: one request per cycle while no solve runs and the result
// output does not stall; each result passes a stage register, then the output.
// Solve: five reads per interior cell per sweep, a step to take the last read
// data and a write on the single grid memory port; result follows the last sweep.
// Reset clears registers to defaults and status to zero; grid cells are
// undefined until written, and no clearing pass runs.
module laplace_gauss_seidel_solver_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // row[5:0], col[11:6], cell_in[43:12], zero
  input  logic [1:0]  s_axis_tuser,  // kind[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // cell_out[31:0], sweep_count[47:32],
                                     // converged[48], zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lgs_pkg::*;

  logic [SizeW-1:0]  size_q;
  logic [TolW-1:0]   tol_q;
  logic [SweepW-1:0] maxsw_q;
  logic [SizeW-1:0]  n;
  logic [IdxW-1:0]   row, col;
  logic [1:0]        kind;
  logic              in_grid, acc;
  logic              st1_v_q, st1_rd_q;
  logic              out_v_q;
  logic [ValW-1:0]   out_cell_q;
  logic [SweepW-1:0] out_sweeps_q;
  logic              out_conv_q;
  logic              out_can, st1_adv;
  mem_req_t          host_req, relax_req, mem_req;
  relax_stat_t       stat;
  logic [ValW-1:0]   rdata;

  // Register access
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= SizeW'(64);
      tol_q   <= TolW'(10486);
      maxsw_q <= SweepW'(65535);
    end else if (psel && penable && pwrite) begin
      case (paddr)
        RegGridSize:  size_q  <= pwdata[SizeW-1:0];
        RegTolerance: tol_q   <= pwdata[TolW-1:0];
        RegMaxSweeps: maxsw_q <= pwdata[SweepW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      RegGridSize:  prdata = {25'b0, size_q};
      RegTolerance: prdata = {1'b0, tol_q};
      RegMaxSweeps: prdata = {16'b0, maxsw_q};
      default:      prdata = '0;
    endcase
  end

  // Clamp grid size
  assign n = (size_q < SizeW'(3)) ? SizeW'(3)
           : (size_q > SizeW'(GridMax)) ? SizeW'(GridMax) : size_q;

  assign kind    = s_axis_tuser;
  assign row     = s_axis_tdata[5:0];
  assign col     = s_axis_tdata[11:6];
  assign in_grid = ({1'b0, row} < n) && ({1'b0, col} < n);

  // Request handshake and result pipeline
  assign out_can       = !out_v_q || m_axis_tready;
  assign st1_adv       = st1_v_q && out_can && !stat.busy;
  assign s_axis_tready = !stat.busy && (!st1_v_q || st1_adv);
  assign acc           = s_axis_tvalid && s_axis_tready;

  assign host_req.re    = acc && (kind == KindRead) && in_grid;
  assign host_req.we    = acc && (kind == KindWrite) && in_grid;
  assign host_req.addr  = {row, col};
  assign host_req.wdata = s_axis_tdata[43:12];
  assign mem_req        = stat.busy ? relax_req : host_req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st1_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (acc) begin
        st1_v_q <= 1'b1;
      end else if (st1_adv) begin
        st1_v_q <= 1'b0;
      end
      if (st1_adv) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Hold payload of the stage and the result, status taken with the result
  always_ff @(posedge clk_i) begin
    if (acc) begin
      st1_rd_q <= (kind == KindRead) && in_grid;
    end
    if (st1_adv) begin
      out_cell_q   <= st1_rd_q ? rdata : '0;
      out_sweeps_q <= stat.sweeps;
      out_conv_q   <= stat.converged;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {7'b0, out_conv_q, out_sweeps_q, out_cell_q};

  lgs_grid_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  lgs_relax u_relax (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (acc && (kind == KindSolve)),
    .size_i  (n),
    .tol_i   (tol_q),
    .cap_i   (maxsw_q),
    .rdata_i (rdata),
    .req_o   (relax_req),
    .stat_o  (stat)
  );
endmodule

/* rtl/lgs_grid_ram.sv */
// Grid cell store: one synchronous port, read data registered.
module lgs_grid_ram (
  input  logic              clk_i,
  input  lgs_pkg::mem_req_t req_i,
  output logic [31:0]       rdata_o
);
  import lgs_pkg::*;

  logic [ValW-1:0] mem [GridMax*GridMax];
  logic [ValW-1:0] rdata_q;

  // Write or read one cell; hold read data otherwise
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;
endmodule

/* rtl/lgs_relax.sv */
// Sweep sequencer: reads five cells per interior point, writes the quarter-sum.
module lgs_relax (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [6:0]           size_i,
  input  logic [30:0]          tol_i,
  input  logic [15:0]          cap_i,
  input  logic [31:0]          rdata_i,
  output lgs_pkg::mem_req_t    req_o,
  output lgs_pkg::relax_stat_t stat_o
);
  import lgs_pkg::*;

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SRd   = 2'd1;
  localparam logic [1:0] SWr   = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [2:0]        k_q, k_d;
  logic [IdxW-1:0]   i_q, i_d, j_q, j_d;
  logic [SweepW-1:0] cnt_q, cnt_d, sweeps_q, sweeps_d;
  logic              conv_q, conv_d;
  logic [ValW:0]     worst_q, worst_d;
  logic [ValW-1:0]   c_q, l_q, r_q, u_q, dn_q;
  logic [IdxW-1:0]   last;
  logic [IdxW-1:0]   ri, rj;
  logic [ValW+1:0]   sum;
  logic [ValW-1:0]   nv;
  logic [ValW:0]     diff, adiff, wmax;
  logic [SweepW-1:0] cap, cnt_inc;

  assign last    = IdxW'(size_i - 7'd2);
  assign cap     = (cap_i == '0) ? SweepW'(1) : cap_i;
  assign cnt_inc = cnt_q + SweepW'(1);

  // Neighbor address for the current read step
  always_comb begin
    ri = i_q;
    rj = j_q;
    case (k_q)
      3'd1:    rj = j_q - IdxW'(1);
      3'd2:    rj = j_q + IdxW'(1);
      3'd3:    ri = i_q - IdxW'(1);
      3'd4:    ri = i_q + IdxW'(1);
      default: ;
    endcase
  end

  // Quarter-sum, floor by arithmetic shift, and absolute change
  assign sum   = {{2{l_q[ValW-1]}}, l_q} + {{2{r_q[ValW-1]}}, r_q}
               + {{2{u_q[ValW-1]}}, u_q} + {{2{dn_q[ValW-1]}}, dn_q};
  assign nv    = sum[ValW+1:2];
  assign diff  = {c_q[ValW-1], c_q} - {nv[ValW-1], nv};
  assign adiff = diff[ValW] ? (~diff + (ValW+1)'(1)) : diff;
  assign wmax  = (adiff > worst_q) ? adiff : worst_q;

  always_comb begin
    state_d  = state_q;
    k_d      = k_q;
    i_d      = i_q;
    j_d      = j_q;
    cnt_d    = cnt_q;
    sweeps_d = sweeps_q;
    conv_d   = conv_q;
    worst_d  = worst_q;
    req_o    = '0;
    req_o.addr  = {ri, rj};
    req_o.wdata = nv;
    case (state_q)
      SIdle: begin
        if (start_i) begin
          state_d = SRd;
          k_d     = '0;
          i_d     = IdxW'(1);
          j_d     = IdxW'(1);
          cnt_d   = '0;
          worst_d = '0;
        end
      end
      SRd: begin
        req_o.re = (k_q != 3'd5);
        k_d      = k_q + 3'd1;
        if (k_q == 3'd5) begin
          state_d = SWr;
        end
      end
      SWr: begin
        // Write back the new value, step to the next point or end the sweep
        req_o.we   = 1'b1;
        req_o.addr = {i_q, j_q};
        worst_d    = wmax;
        k_d        = '0;
        state_d    = SRd;
        if (j_q != last) begin
          j_d = j_q + IdxW'(1);
        end else if (i_q != last) begin
          j_d = IdxW'(1);
          i_d = i_q + IdxW'(1);
        end else begin
          cnt_d = cnt_inc;
          i_d   = IdxW'(1);
          j_d   = IdxW'(1);
          if (wmax > {2'b0, tol_i} && cnt_inc < cap) begin
            worst_d = '0;
          end else begin
            state_d  = SIdle;
            sweeps_d = cnt_inc;
            conv_d   = (wmax <= {2'b0, tol_i});
          end
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      k_q      <= '0;
      i_q      <= '0;
      j_q      <= '0;
      cnt_q    <= '0;
      sweeps_q <= '0;
      conv_q   <= 1'b0;
      worst_q  <= '0;
    end else begin
      state_q  <= state_d;
      k_q      <= k_d;
      i_q      <= i_d;
      j_q      <= j_d;
      cnt_q    <= cnt_d;
      sweeps_q <= sweeps_d;
      conv_q   <= conv_d;
      worst_q  <= worst_d;
    end
  end

  // Capture each read's data in the step that follows its request
  always_ff @(posedge clk_i) begin
    if (state_q == SRd) begin
      case (k_q)
        3'd1:    c_q  <= rdata_i;
        3'd2:    l_q  <= rdata_i;
        3'd3:    r_q  <= rdata_i;
        3'd4:    u_q  <= rdata_i;
        3'd5:    dn_q <= rdata_i;
        default: ;
      endcase
    end
  end

  assign stat_o.busy      = (state_q != SIdle);
  assign stat_o.sweeps    = sweeps_q;
  assign stat_o.converged = conv_q;
endmodule

/* tb/sv/tb_laplace_gauss_seidel_solver_core.sv */
// Self-checking testbench of the Laplace Gauss-Seidel solver core.
`timescale 1ns / 100ps

module tb_laplace_gauss_seidel_solver_core;
  import lgs_pkg::*;

  localparam logic [1:0] KindNone = 2'd3;
  localparam int ItemTarget = 1650;

  typedef struct {
    logic [1:0]  kind;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [31:0] val;
  } cell_req_t;

  typedef struct {
    logic [31:0] cell_val;
    logic [15:0] sweeps;
    logic        conv;
  } cell_res_t;

  typedef struct {
    bit          is_cfg;
    logic [3:0]  addr;
    logic [31:0] data;
    cell_req_t   rq;
    bit          typed;
    cell_res_t   res;
  } step_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;  // row[5:0], col[11:6], cell_in[43:12], zero
  logic [1:0]  s_axis_tuser = '0;  // kind[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;       // cell_out[31:0], sweep_count[47:32], converged[48]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  laplace_gauss_seidel_solver_core i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #6 clk_i = ~clk_i;

  // Grid mirror, registers and status
  logic signed [31:0] grid_mem [0:4095];
  bit                 written  [0:4095];
  int unsigned        cfg_size = 64, cfg_tol = 10486, cfg_cap = 65535;
  logic [15:0]        last_sweeps = '0;
  logic               last_conv = 1'b0;

  cell_res_t   pending_q[$];
  step_t       directed_q[$];
  int          errors = 0;
  int          sent = 0;
  longint      cycles = 0;
  longint      cycle_limit = 400000;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;

  function automatic int unsigned eff_n();
    if (cfg_size < 3) return 3;
    if (cfg_size > GridMax) return GridMax;
    return cfg_size;
  endfunction

  // Apply one request to the mirror and return the result it should produce
  function automatic cell_res_t relax_and_respond(cell_req_t r);
    cell_res_t   o;
    int unsigned n, cap, cnt;
    longint      worst, nv, oldv, d;
    int          a;
    n = eff_n();
    o.cell_val = '0;
    cycle_limit += 64;
    case (r.kind)
      KindWrite: if (r.row < n && r.col < n) begin
        grid_mem[{r.row, r.col}] = r.val;
        written[{r.row, r.col}] = 1'b1;
      end
      KindSolve: begin
        cap = (cfg_cap == 0) ? 1 : cfg_cap;
        cnt = 0;
        do begin
          worst = 0;
          cnt++;
          for (int i = 1; i + 1 < n; i++) begin
            for (int j = 1; j + 1 < n; j++) begin
              a = i * GridMax + j;
              oldv = grid_mem[a];
              nv = (longint'(grid_mem[a + 1]) + grid_mem[a - 1] + grid_mem[a + GridMax]
                    + grid_mem[a - GridMax]) >>> 2;
              d = (oldv >= nv) ? oldv - nv : nv - oldv;
              grid_mem[a] = nv[31:0];
              if (d > worst) worst = d;
            end
          end
        end while (worst > longint'(cfg_tol) && cnt < cap);
        last_sweeps = cnt[15:0];
        last_conv = (worst <= longint'(cfg_tol));
        cycle_limit += 4 * (6 * (n - 2) * (n - 2) + 8) * cnt + 100;
      end
      KindRead: if (r.row < n && r.col < n) o.cell_val = grid_mem[{r.row, r.col}];
      default: ;
    endcase
    o.sweeps = last_sweeps;
    o.conv = last_conv;
    return o;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch in %s: got %h, want %h", what, got, want);
    errors++;
  endtask

  // Compare every result against the oldest expectation
  always @(posedge clk_i) begin
    cell_res_t e;
    cycles++;
    if (cycles > cycle_limit) begin
      $display("simulation failed");
      $finish;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_q.size() == 0) begin
        report("unexpected result", m_axis_tdata[31:0], '0);
      end else begin
        e = pending_q.pop_front();
        if (m_axis_tdata[31:0] !== e.cell_val)
          report("cell_out", m_axis_tdata[31:0], e.cell_val);
        if (m_axis_tdata[47:32] !== e.sweeps)
          report("sweep_count", {16'b0, m_axis_tdata[47:32]}, {16'b0, e.sweeps});
        if (m_axis_tdata[48] !== e.conv)
          report("converged", {31'b0, m_axis_tdata[48]}, {31'b0, e.conv});
      end
    end
  end

  // Result side: random stalls, plus a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = 400;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready <= calm || ($urandom_range(0, 99) >= 31);
    end
  end

  // Offer one request, wait for acceptance; returns at a falling edge
  task automatic send(cell_req_t r, bit typed = 0, cell_res_t tres = '{default: '0});
    cell_res_t p;
    if (!calm) begin
      while ($urandom_range(0, 99) < 31) begin
        s_axis_tvalid <= 1'b0;
        @(negedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= r.kind;
    s_axis_tdata <= {4'b0, r.val, r.col, r.row};
    do @(posedge clk_i); while (!s_axis_tready);
    p = relax_and_respond(r);
    pending_q.push_back(typed ? tres : p);
    sent++;
    @(negedge clk_i);
  endtask

  // Stop offering until every result has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic reg_write(logic [3:0] addr, logic [31:0] data);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (addr)
      RegGridSize:  cfg_size = data & 32'h7F;
      RegTolerance: cfg_tol = data & 32'h7FFF_FFFF;
      RegMaxSweeps: cfg_cap = data & 32'hFFFF;
      default: ;
    endcase
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
    endcase
  endfunction

  function automatic cell_req_t mk(logic [1:0] k, logic [5:0] r, logic [5:0] c,
                                   logic [31:0] v);
    cell_req_t q;
    q.kind = k;
    q.row = r;
    q.col = c;
    q.val = v;
    return q;
  endfunction

  function automatic void add_req(cell_req_t r, bit typed = 0, logic [31:0] cval = '0);
    step_t s;
    s.is_cfg = 0;
    s.rq = r;
    s.typed = typed;
    s.res.cell_val = cval;
    s.res.sweeps = '0;
    s.res.conv = 1'b0;
    directed_q.push_back(s);
  endfunction

  function automatic void add_cfg(logic [3:0] addr, logic [31:0] data);
    step_t s;
    s.is_cfg = 1;
    s.addr = addr;
    s.data = data;
    directed_q.push_back(s);
  endfunction

  initial begin
    int unsigned n, ops;
    cell_req_t   r;
    int          p;
    bit          big, found;

    // Directed table: reset defaults, extremes, clamped sizes and caps
    add_req(mk(KindNone, 6'h3F, 6'h3F, 32'hFFFF_FFFF), 1, 32'h0);
    add_req(mk(KindWrite, 6'h3F, 6'h3F, 32'h7FFF_FFFF));
    add_req(mk(KindRead, 6'h3F, 6'h3F, 32'h0), 1, 32'h7FFF_FFFF);
    add_req(mk(KindWrite, 6'h0, 6'h0, 32'h8000_0000));
    add_req(mk(KindRead, 6'h0, 6'h0, 32'h0), 1, 32'h8000_0000);
    add_cfg(RegGridSize, 32'h0);
    add_cfg(RegTolerance, 32'h0);
    add_cfg(RegMaxSweeps, 32'h0);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        add_req(mk(KindWrite, 6'(i), 6'(j),
                   (i == 1 && j == 1) ? 32'h7FFF_FFFF : 32'h8000_0000));
    add_req(mk(KindSolve, 6'h0, 6'h0, 32'h0));
    add_req(mk(KindRead, 6'h1, 6'h1, 32'h0));
    add_req(mk(KindRead, 6'h3, 6'h3, 32'h0));
    add_cfg(RegMaxSweeps, 32'hFFFF);
    add_cfg(RegTolerance, 32'h7FFF_FFFF);
    add_req(mk(KindSolve, 6'h0, 6'h0, 32'h0));
    add_cfg(RegGridSize, 32'h7F);
    add_req(mk(KindWrite, 6'h3F, 6'h0, 32'h0012_3456));
    add_req(mk(KindRead, 6'h3F, 6'h0, 32'h0));

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_q[k]) begin
      if (directed_q[k].is_cfg) begin
        drain();
        reg_write(directed_q[k].addr, directed_q[k].data);
      end else begin
        send(directed_q[k].rq, directed_q[k].typed, directed_q[k].res);
      end
    end

    // Random phases: reconfigure, fill the grid unless big, then mixed traffic
    p = 0;
    while (sent < ItemTarget + 17) begin
      drain();
      big = (p % 9 == 5);
      calm = (p == 3);
      if (big) reg_write(RegGridSize, $urandom_range(0, 1) ? 32'h7F : 32'h40);
      else if ($urandom_range(0, 9) == 0) reg_write(RegGridSize, $urandom_range(0, 2));
      else reg_write(RegGridSize, $urandom_range(3, 7));
      n = eff_n();
      case ($urandom_range(0, 3))
        0: reg_write(RegTolerance, 32'h0);
        1: reg_write(RegTolerance, $urandom_range(0, 4096));
        2: reg_write(RegTolerance, 32'h7FFF_FFFF);
        default: reg_write(RegTolerance, $urandom);
      endcase
      if (n == 3 && $urandom_range(0, 2) == 0) reg_write(RegMaxSweeps, 32'hFFFF);
      else if ($urandom_range(0, 9) == 0) reg_write(RegMaxSweeps, 32'h0);
      else reg_write(RegMaxSweeps, {$urandom_range(0, 1) ? 16'h0 : 16'hFFFF, 16'h0}
                                     | $urandom_range(1, 20));
      if (!big)
        for (int i = 0; i < n; i++)
          for (int j = 0; j < n; j++)
            send(mk(KindWrite, 6'(i), 6'(j), rand_val()));
      if (p == 2) hold_req = 1'b1;
      ops = big ? 40 : 30;
      repeat (ops) begin
        case ($urandom_range(0, 99)) inside
          [0:44]: begin
            r = mk(KindWrite, 6'($urandom), 6'($urandom), rand_val());
            if ($urandom_range(0, 3) != 0) begin
              r.row = 6'($urandom_range(0, n - 1));
              r.col = 6'($urandom_range(0, n - 1));
            end
          end
          [45:79]: begin
            found = 0;
            for (int t = 0; t < 16 && !found; t++) begin
              r = mk(KindRead, 6'($urandom), 6'($urandom), $urandom);
              if ($urandom_range(0, 3) != 0) begin
                r.row = 6'($urandom_range(0, n - 1));
                r.col = 6'($urandom_range(0, n - 1));
              end
              found = (r.row >= n || r.col >= n || written[{r.row, r.col}]);
            end
            if (!found) r.kind = KindNone;
          end
          [80:91]: r = mk(big ? KindNone : KindSolve, 6'($urandom), 6'($urandom), $urandom);
          default: r = mk(KindNone, 6'($urandom), 6'($urandom), $urandom);
        endcase
        send(r);
      end
      p++;
    end

    // Final wait for outstanding results
    calm = 1'b0;
    drain();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
